>>> rtl/core/tdm_tone_channel_scheduler_top_assert.svh
// Assertion macros used by the scheduler top.
`ifndef TDM_TONE_CHANNEL_SCHEDULER_TOP_ASSERT_SVH
`define TDM_TONE_CHANNEL_SCHEDULER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define TTS_CHECK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check an implication that must hold in the next cycle.
`define TTS_NEXT(name, cond, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

>>> rtl/core/tts_pkg.sv
`timescale 1ns / 1ps
package tts_pkg;

  localparam int unsigned ChanW = 15;
  localparam int unsigned ChanDepth = 4;
  localparam int unsigned WaveDepth = 16;
  localparam int unsigned QuotW = 18;
  localparam int unsigned DivisorW = 20;
  localparam int unsigned HzW = 22;
  localparam logic [15:0] MinToneReset = 16'd65;
  localparam logic [15:0] MaxToneReset = 16'd16000;
  localparam logic [QuotW-1:0] PulseNum = 18'd131072;
  localparam logic [QuotW-1:0] WaveNum = 18'd65536;
  // 4194304 / x >> 7 folds to 32768 / x
  localparam logic [QuotW-1:0] NoiseNum = 18'd32768;
  localparam logic [11:0] PeriodBase = 12'd2048;
  localparam logic [10:0] NoiseShiftLimit = 11'd13;

  typedef enum logic [1:0] {
    OP_SET_CHANNEL = 2'd0,
    OP_WRITE_WAVE  = 2'd1,
    OP_TICK        = 2'd2,
    OP_UNUSED      = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    CH_PULSE0 = 2'd0,
    CH_PULSE1 = 2'd1,
    CH_WAVE   = 2'd2,
    CH_NOISE  = 2'd3
  } chan_id_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WREAD, ST_CREAD, ST_CDATA, ST_DIV, ST_CHECK, ST_DONE
  } state_t;

  typedef struct packed {
    logic        active;
    logic [10:0] period;
    logic [2:0]  divider;
  } chan_entry_t;

  typedef struct packed {
    logic                 start;
    logic [QuotW-1:0]     dividend;
    logic [DivisorW-1:0]  divisor;
  } div_req_t;

  function automatic logic [6:0] noise_div(input logic [2:0] r);
    logic [6:0] v;
    unique case (r)
      3'd0: v = 7'd8;
      3'd1: v = 7'd16;
      3'd2: v = 7'd32;
      3'd3: v = 7'd48;
      3'd4: v = 7'd64;
      3'd5: v = 7'd80;
      3'd6: v = 7'd96;
      default: v = 7'd112;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/tts_store.sv
`timescale 1ns / 1ps
module tts_store
  import tts_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                chan_we,
  input  logic [1:0]          chan_waddr,
  input  chan_entry_t         chan_wdata,
  input  logic [1:0]          chan_raddr,
  output chan_entry_t         chan_rdata,
  input  logic                wave_we,
  input  logic [3:0]          wave_waddr,
  input  logic [7:0]          wave_wdata,
  input  logic [3:0]          wave_raddr,
  output logic [7:0]          wave_rdata
);

  chan_entry_t chan_mem [ChanDepth];
  logic [7:0]  wave_mem [WaveDepth];
  logic [ChanDepth-1:0] chan_vld;
  logic [WaveDepth-1:0] wave_vld;
  chan_entry_t chan_q;
  logic [7:0]  wave_q;
  logic        chan_q_vld;
  logic        wave_q_vld;

  always_ff @(posedge clk) begin
    if (chan_we) begin
      chan_mem[chan_waddr] <= chan_wdata;
    end
    if (wave_we) begin
      wave_mem[wave_waddr] <= wave_wdata;
    end
    chan_q <= chan_mem[chan_raddr];
    wave_q <= wave_mem[wave_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_vld <= '0;
      wave_vld <= '0;
      chan_q_vld <= 1'b0;
      wave_q_vld <= 1'b0;
    end else begin
      if (chan_we) begin
        chan_vld[chan_waddr] <= 1'b1;
      end
      if (wave_we) begin
        wave_vld[wave_waddr] <= 1'b1;
      end
      chan_q_vld <= chan_vld[chan_raddr];
      wave_q_vld <= wave_vld[wave_raddr];
    end
  end

  // never-written entries read as zero
  assign chan_rdata = chan_q_vld ? chan_q : '0;
  assign wave_rdata = wave_q_vld ? wave_q : 8'd0;

endmodule

>>> rtl/core/tts_div.sv
`timescale 1ns / 1ps
module tts_div
  import tts_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [QuotW-1:0] quotient
);

  logic [QuotW-1:0]    quot;
  logic [DivisorW-1:0] rem;
  logic [DivisorW-1:0] dsor;
  logic [4:0]          count;
  logic                busy;
  logic [DivisorW:0]   trial;
  logic                fits;

  assign trial = {rem, quot[QuotW-1]};
  assign fits = trial >= {1'b0, dsor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 5'(QuotW);
      end else if (busy) begin
        count <= count - 5'd1;
        if (count == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // one quotient bit per cycle while busy, MSB first
  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem <= '0;
      dsor <= req.divisor;
    end else if (busy) begin
      quot <= {quot[QuotW-2:0], fits};
      rem <= fits ? DivisorW'(trial - {1'b0, dsor}) : trial[DivisorW-1:0];
    end
  end

  assign quotient = quot;

endmodule

>>> rtl/core/tdm_tone_channel_scheduler_top.sv
`timescale 1ns / 1ps
// Tone picker for one square-wave buzzer. Set-channel and wave-write items
// are taken without leaving the idle state. A tick item first reads all 16
// wave bytes, then tries up to four channels from the round-robin slot. A
// tried channel passes the table read, table data and range check states,
// and one that needs a divide (active, and for noise a shift below 13) adds
// a serial divide in between. A tick's result waits in the done state while
// the previous result is still stalled, and the block returns to idle before
// the next item is taken. The divider yields one quotient bit per cycle and
// the wave store has one read port. The result register frees the input
// while a result waits to be taken.
module tdm_tone_channel_scheduler_top
  import tts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  opcode,
  input  logic [1:0]  channel_index,
  input  logic        channel_active,
  input  logic [10:0] period_or_shift,
  input  logic [2:0]  divider_index,
  input  logic [3:0]  wave_address,
  input  logic [7:0]  wave_data,
  output logic        result_valid,
  input  logic        result_stall,
  output logic        tone_on,
  output logic [15:0] tone_hz,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

`include "tdm_tone_channel_scheduler_top_assert.svh"

  state_t state, state_next;
  logic [15:0] min_tone, max_tone;
  logic [1:0]  slot, step;
  logic [4:0]  cnt;
  logic [127:0] shadow;
  logic        zero_tone;
  logic [1:0]  cur_chan;
  logic        accept;
  chan_entry_t chan_rdata;
  logic [7:0]  wave_rdata;
  div_req_t    div_req;
  logic        div_done;
  logic [QuotW-1:0] quotient;
  logic [2:0]  rep_shift;
  logic [HzW-1:0] hz;
  logic        found;
  logic        skip;
  logic [DivisorW-1:0] noise_dsor;
  logic        pend_on;
  logic [15:0] pend_hz;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? {16'd0, max_tone} : {16'd0, min_tone};

  always_ff @(posedge clk) begin
    if (rst) begin
      min_tone <= MinToneReset;
      max_tone <= MaxToneReset;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        max_tone <= pwdata[15:0];
      end else begin
        min_tone <= pwdata[15:0];
      end
    end
  end

  assign accept = item_valid && !item_stall;
  assign cur_chan = slot + step;

  tts_store u_store (
    .clk        (clk),
    .rst        (rst),
    .chan_we    (accept && opcode == OP_SET_CHANNEL),
    .chan_waddr (channel_index),
    .chan_wdata ({channel_active, period_or_shift, divider_index}),
    .chan_raddr (cur_chan),
    .chan_rdata (chan_rdata),
    .wave_we    (accept && opcode == OP_WRITE_WAVE),
    .wave_waddr (wave_address),
    .wave_wdata (wave_data),
    .wave_raddr (cnt[3:0]),
    .wave_rdata (wave_rdata)
  );

  tts_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // shortest repeat period over the 32 nibbles, shadow holds sample 0 on top
  always_comb begin
    if (shadow[127:8] == shadow[119:0]) begin
      rep_shift = 3'd4;
    end else if (shadow[127:16] == shadow[111:0]) begin
      rep_shift = 3'd3;
    end else if (shadow[127:32] == shadow[95:0]) begin
      rep_shift = 3'd2;
    end else if (shadow[127:64] == shadow[63:0]) begin
      rep_shift = 3'd1;
    end else begin
      rep_shift = 3'd0;
    end
  end

  assign hz = zero_tone ? '0
            : (HzW'(quotient) << ((cur_chan == CH_WAVE) ? rep_shift : 3'd0));
  assign found = (hz != '0) && (hz >= HzW'(min_tone)) && (hz <= HzW'(max_tone));
  assign skip = !chan_rdata.active
             || (cur_chan == CH_NOISE && chan_rdata.period >= NoiseShiftLimit);
  assign noise_dsor = DivisorW'(noise_div(chan_rdata.divider)) << chan_rdata.period[3:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && opcode == OP_TICK) state_next = ST_WREAD;
      ST_WREAD: if (cnt == 5'(WaveDepth)) state_next = ST_CREAD;
      ST_CREAD: state_next = ST_CDATA;
      ST_CDATA: state_next = skip ? ST_CHECK : ST_DIV;
      ST_DIV:   if (div_done) state_next = ST_CHECK;
      ST_CHECK: begin
        if (found || step == 2'd3) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_CREAD;
        end
      end
      ST_DONE:  if (!result_valid || !result_stall) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall = state != ST_IDLE;
    div_req = '0;
    if (state == ST_CDATA && !skip) begin
      div_req.start = 1'b1;
      unique case (cur_chan)
        CH_PULSE0, CH_PULSE1: begin
          div_req.dividend = PulseNum;
          div_req.divisor = DivisorW'(PeriodBase - {1'b0, chan_rdata.period});
        end
        CH_WAVE: begin
          div_req.dividend = WaveNum;
          div_req.divisor = DivisorW'(PeriodBase - {1'b0, chan_rdata.period});
        end
        default: begin
          div_req.dividend = NoiseNum;
          div_req.divisor = noise_dsor;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot <= 2'd3;
      step <= '0;
      cnt <= '0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DONE && (!result_valid || !result_stall)) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          cnt <= '0;
          step <= '0;
          if (accept && opcode == OP_TICK) begin
            slot <= slot + 2'd1;
          end
        end
        ST_WREAD: cnt <= cnt + 5'd1;
        ST_CHECK: if (!found && step != 2'd3) step <= step + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    // shift in the byte read on the previous cycle
    if (state == ST_WREAD && cnt != 5'd0) begin
      shadow <= {shadow[119:0], wave_rdata};
    end
    if (state == ST_CDATA) begin
      zero_tone <= skip;
    end
    if (state == ST_CHECK) begin
      pend_on <= found;
      pend_hz <= found ? hz[15:0] : 16'd0;
    end
    // hold the waiting result until its transfer
    if (state == ST_DONE && (!result_valid || !result_stall)) begin
      tone_on <= pend_on;
      tone_hz <= pend_hz;
    end
  end

  `TTS_CHECK(a_on_matches_hz, result_valid |-> (tone_on == (tone_hz != 16'd0)), "tone_on disagrees with tone_hz")
  `TTS_NEXT(a_tick_starts, accept && opcode == OP_TICK, state == ST_WREAD, "tick did not start wave read")
  `TTS_CHECK(a_result_from_done, $rose(result_valid) |-> $past(state) == ST_DONE, "result without finished search")

endmodule
